/* hdl/kll_pkg.sv */
// ============================================================================
// kll_pkg: shared types and constants for the k-means clustering engine
// Holds field widths, mode and register codes, default sizes and the
// command and status words between controller and datapath.
// ============================================================================
package kll_pkg;

    localparam int DEF_MAX_POINTS   = 1024;
    localparam int DEF_MAX_CLUSTERS = 8;
    localparam int DEF_MAX_DIMS     = 8;

    localparam int COORD_W = 16;
    localparam int ITER_W  = 16;
    localparam int ITEM_W  = 10;
    localparam int CIDX_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int SQ_W    = 32;

    localparam logic [1:0] MODE_LOAD_POINT    = 2'd0;
    localparam logic [1:0] MODE_LOAD_CENTROID = 2'd1;
    localparam logic [1:0] MODE_RUN           = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EPS          = 3'd4;

    typedef struct packed {
        logic                ld_pt;
        logic                ld_cen;
        logic                run_start;
        logic                iter_clr;
        logic                sum_clr_wr;
        logic                a_rd;
        logic                sq_ab;
        logic                dist_acc;
        logic                first;
        logic                best_upd;
        logic                u_rd;
        logic                cnt_inc;
        logic                u_wr;
        logic                move_clr;
        logic                m_rd;
        logic                div_start;
        logic                sq_mc;
        logic                cen_wr;
        logic                move_acc;
        logic                max_upd;
        logic                o_rd;
        logic                out_load;
        logic                out_last;
        logic                out_err;
        logic [ITEM_W-1:0]   item;
        logic [CIDX_W-1:0]   coord;
        logic [COORD_W-1:0]  value;
        logic [CFG_DATA_W-1:0] eps;
        logic [ITER_W-1:0]   iter;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic div_done;
        logic converged;
        logic out_busy;
    } t_sts;

endpackage

/* hdl/kll_div.sv */
// ============================================================================
// kll_div: signed by unsigned iterative divider
// Restoring division, one quotient bit per cycle, quotient truncated
// toward zero. Pulses o_done when the quotient is ready.
// ============================================================================
module kll_div import kll_pkg::*; #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]        i_den,
    output logic signed [NUM_W-1:0] o_quot,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [NUM_W-1:0] r_num, n_num;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den, n_den;
    logic             r_neg, n_neg;
    logic [DEN_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        trial  = {r_rem[DEN_W-1:0], r_num[NUM_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W);
            n_num  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            n_rem  = '0;
            n_den  = i_den;
            n_neg  = i_num[NUM_W-1];
        end else if (r_busy) begin
            // The remainder stays below the divisor, so the shifted value fits.
            if (trial >= {1'b0, r_den}) begin
                n_rem = trial - {1'b0, r_den};
                n_num = {r_num[NUM_W-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_num = {r_num[NUM_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_quot = r_neg ? -$signed(r_num) : $signed(r_num);
    assign o_done = r_done;

endmodule

/* hdl/kll_datapath.sv */
// ============================================================================
// kll_datapath: stores, arithmetic and result register
// Holds the point, centroid and sum memories, the cluster counts, the
// distance and movement accumulators, the divider and the output word.
// ============================================================================
module kll_datapath import kll_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    parameter int PW = (MAX_POINTS   > 1) ? $clog2(MAX_POINTS)   : 1,
    parameter int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    parameter int DW = (MAX_DIMS     > 1) ? $clog2(MAX_DIMS)     : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    input  logic [PW-1:0]             i_p,
    input  logic [CW-1:0]             i_c,
    input  logic [DW-1:0]             i_j,
    output t_sts                      o_sts,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [CIDX_W-1:0]         o_cluster_index,
    output logic [CIDX_W-1:0]         o_out_coord_index,
    output logic signed [COORD_W-1:0] o_centroid_value,
    output logic                      o_status,
    output logic [ITER_W-1:0]         o_iterations_done,
    output logic                      o_last
);

    localparam int PT_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int CN_DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int PA_W = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int CA_W = (CN_DEPTH > 1) ? $clog2(CN_DEPTH) : 1;
    localparam int SUM_W  = COORD_W + PW;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int DIST_W = SQ_W + $clog2(MAX_DIMS + 1);

    logic signed [COORD_W-1:0] point_mem [PT_DEPTH];
    logic signed [COORD_W-1:0] cen_mem   [CN_DEPTH];
    logic signed [SUM_W-1:0]   sum_mem   [CN_DEPTH];
    logic [CNT_W-1:0]          r_count   [MAX_CLUSTERS];

    logic signed [COORD_W-1:0] r_pt_q, r_cen_q;
    logic signed [SUM_W-1:0]   r_sum_q;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_dist, r_best_d, r_move, r_max_move;
    logic [CW-1:0]             r_best;
    logic [SQ_W-1:0]           r_eps_sq;

    logic                      r_o_valid;
    logic [CIDX_W-1:0]         r_o_cl, r_o_co;
    logic signed [COORD_W-1:0] r_o_val;
    logic                      r_o_st, r_o_last;
    logic [ITER_W-1:0]         r_o_it;

    logic [PA_W-1:0]           pt_rd_addr, pt_wr_addr;
    logic [CA_W-1:0]           cen_rd_addr, cen_wr_addr, sum_rd_addr, sum_wr_addr;
    logic [CA_W-1:0]           ld_cen_addr;
    logic                      pt_ok, cen_ok;
    logic [CW-1:0]             cnt_idx;
    logic [CNT_W-1:0]          cnt_val;
    logic signed [SUM_W-1:0]   quot;
    logic                      div_done;
    logic signed [COORD_W-1:0] mean;
    logic signed [COORD_W:0]   diff;
    logic signed [2*COORD_W+1:0] prod;

    assign pt_ok  = (32'(i_cmd.item)  < 32'(MAX_POINTS))   && (32'(i_cmd.coord) < 32'(MAX_DIMS));
    assign cen_ok = (32'(i_cmd.item)  < 32'(MAX_CLUSTERS)) && (32'(i_cmd.coord) < 32'(MAX_DIMS));

    assign pt_rd_addr  = PA_W'(i_p) * PA_W'(MAX_DIMS) + PA_W'(i_j);
    assign pt_wr_addr  = PA_W'(i_cmd.item) * PA_W'(MAX_DIMS) + PA_W'(i_cmd.coord);
    assign cen_rd_addr = CA_W'(i_c) * CA_W'(MAX_DIMS) + CA_W'(i_j);
    assign ld_cen_addr = CA_W'(i_cmd.item) * CA_W'(MAX_DIMS) + CA_W'(i_cmd.coord);
    assign cen_wr_addr = i_cmd.ld_cen ? ld_cen_addr : cen_rd_addr;
    assign sum_rd_addr = CA_W'(i_cmd.u_rd ? r_best : i_c) * CA_W'(MAX_DIMS) + CA_W'(i_j);
    assign sum_wr_addr = CA_W'(i_cmd.u_wr ? r_best : i_c) * CA_W'(MAX_DIMS) + CA_W'(i_j);

    assign mean = quot[COORD_W-1:0];

    always_comb begin
        if (i_cmd.sq_mc) begin
            diff = {mean[COORD_W-1], mean} - {r_cen_q[COORD_W-1], r_cen_q};
        end else begin
            diff = {r_pt_q[COORD_W-1], r_pt_q} - {r_cen_q[COORD_W-1], r_cen_q};
        end
        prod = diff * diff;
    end

    assign cnt_idx = i_cmd.cnt_inc ? r_best : i_c;
    assign cnt_val = r_count[cnt_idx];

    // Memories: one write and one registered read each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_pt && pt_ok) begin
            point_mem[pt_wr_addr] <= i_cmd.value;
        end
        if (i_cmd.a_rd || i_cmd.u_rd) begin
            r_pt_q <= point_mem[pt_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.ld_cen && cen_ok) || i_cmd.cen_wr) begin
            cen_mem[cen_wr_addr] <= i_cmd.ld_cen ? i_cmd.value : mean;
        end
        if (i_cmd.a_rd || i_cmd.m_rd || i_cmd.o_rd) begin
            r_cen_q <= cen_mem[cen_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_clr_wr || i_cmd.u_wr) begin
            sum_mem[sum_wr_addr] <= i_cmd.sum_clr_wr ? '0
                                  : r_sum_q + SUM_W'(r_pt_q);
        end
        if (i_cmd.u_rd || i_cmd.m_rd) begin
            r_sum_q <= sum_mem[sum_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_CLUSTERS; k++) begin
            if (i_cmd.iter_clr) begin
                r_count[k] <= '0;
            end else if (i_cmd.cnt_inc && (CW'(k) == r_best)) begin
                r_count[k] <= r_count[k] + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_eps_sq <= SQ_W'(i_cmd.eps) * SQ_W'(i_cmd.eps);
        end
        if (i_cmd.sq_ab || i_cmd.sq_mc) begin
            r_sq <= SQ_W'(prod);
        end
        if (i_cmd.dist_acc) begin
            r_dist <= (i_cmd.first ? '0 : r_dist) + DIST_W'(r_sq);
        end
        if (i_cmd.best_upd && (i_cmd.first || r_dist < r_best_d)) begin
            r_best   <= i_c;
            r_best_d <= r_dist;
        end
        if (i_cmd.move_clr) begin
            r_move <= '0;
        end else if (i_cmd.move_acc) begin
            r_move <= r_move + DIST_W'(r_sq);
        end
        if (i_cmd.iter_clr) begin
            r_max_move <= '0;
        end else if (i_cmd.max_upd && r_move > r_max_move) begin
            r_max_move <= r_move;
        end
    end

    kll_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_sum_q),
        .i_den   (cnt_val),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_o_cl   <= i_cmd.out_err ? '0 : CIDX_W'(i_c);
            r_o_co   <= i_cmd.out_err ? '0 : CIDX_W'(i_j);
            r_o_val  <= i_cmd.out_err ? '0 : r_cen_q;
            r_o_st   <= i_cmd.out_err;
            r_o_it   <= i_cmd.iter;
            r_o_last <= i_cmd.out_last;
        end
    end

    assign o_sts.count_zero = (cnt_val == '0);
    assign o_sts.div_done   = div_done;
    assign o_sts.converged  = r_max_move < DIST_W'(r_eps_sq);
    assign o_sts.out_busy   = r_o_valid && !i_out_ready;

    assign o_out_valid       = r_o_valid;
    assign o_cluster_index   = r_o_cl;
    assign o_out_coord_index = r_o_co;
    assign o_centroid_value  = r_o_val;
    assign o_status          = r_o_st;
    assign o_iterations_done = r_o_it;
    assign o_last            = r_o_last;

endmodule

/* hdl/kll_ctrl.sv */
// ============================================================================
// kll_ctrl: configuration registers and run sequencer
// Walks points, clusters and coordinates through the assignment, update
// and report phases and drives the datapath with command words.
// ============================================================================
module kll_ctrl import kll_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS,
    parameter int PW = (MAX_POINTS   > 1) ? $clog2(MAX_POINTS)   : 1,
    parameter int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
    parameter int DW = (MAX_DIMS     > 1) ? $clog2(MAX_DIMS)     : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_mode,
    input  logic [ITEM_W-1:0]     i_item_index,
    input  logic [CIDX_W-1:0]     i_coord_index,
    input  logic [COORD_W-1:0]    i_coord_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_sts                  i_sts,
    output t_cmd                  o_cmd,
    output logic [PW-1:0]         o_p,
    output logic [CW-1:0]         o_c,
    output logic [DW-1:0]         o_j
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CLR    = 5'd1;
    localparam logic [4:0] S_A_RD   = 5'd2;
    localparam logic [4:0] S_A_SQ   = 5'd3;
    localparam logic [4:0] S_A_ACC  = 5'd4;
    localparam logic [4:0] S_A_CMP  = 5'd5;
    localparam logic [4:0] S_U_RD   = 5'd6;
    localparam logic [4:0] S_U_WR   = 5'd7;
    localparam logic [4:0] S_M_CHK  = 5'd8;
    localparam logic [4:0] S_M_RD   = 5'd9;
    localparam logic [4:0] S_M_DGO  = 5'd10;
    localparam logic [4:0] S_M_DWT  = 5'd11;
    localparam logic [4:0] S_M_MV   = 5'd12;
    localparam logic [4:0] S_M_ACC  = 5'd13;
    localparam logic [4:0] S_M_MAX  = 5'd14;
    localparam logic [4:0] S_IT_END = 5'd15;
    localparam logic [4:0] S_O_RD   = 5'd16;
    localparam logic [4:0] S_O_SEND = 5'd17;
    localparam logic [4:0] S_ERR    = 5'd18;

    logic [3:0]        r_k, r_d;
    logic [10:0]       r_np;
    logic [ITER_W-1:0] r_max_it, r_eps;

    logic [4:0]        r_state, n_state;
    logic [PW-1:0]     r_p, n_p;
    logic [CW-1:0]     r_c, n_c;
    logic [DW-1:0]     r_j, n_j;
    logic [ITER_W-1:0] r_iter, n_iter;

    logic [CW-1:0]     k_last;
    logic [DW-1:0]     d_last;
    logic [PW-1:0]     p_last;
    logic              j_end, c_end, p_end;
    logic [ITER_W:0]   iter_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= 4'd1;
            r_d      <= 4'd1;
            r_np     <= 11'd1;
            r_max_it <= 16'd300;
            r_eps    <= 16'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_NUM_CLUSTERS: r_k      <= i_cfg_data[3:0];
                REG_NUM_DIMS:     r_d      <= i_cfg_data[3:0];
                REG_NUM_POINTS:   r_np     <= i_cfg_data[10:0];
                REG_MAX_ITER:     r_max_it <= i_cfg_data;
                REG_EPS:          r_eps    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Counts of zero or beyond the store size are saturated.
    always_comb begin
        int k_i, d_i, p_i;
        k_i = (r_k  == '0) ? 1 : ((32'(r_k)  > MAX_CLUSTERS) ? MAX_CLUSTERS : 32'(r_k));
        d_i = (r_d  == '0) ? 1 : ((32'(r_d)  > MAX_DIMS)     ? MAX_DIMS     : 32'(r_d));
        p_i = (r_np == '0) ? 1 : ((32'(r_np) > MAX_POINTS)   ? MAX_POINTS   : 32'(r_np));
        k_last = CW'(k_i - 1);
        d_last = DW'(d_i - 1);
        p_last = PW'(p_i - 1);
    end

    assign j_end    = (r_j == d_last);
    assign c_end    = (r_c == k_last);
    assign p_end    = (r_p == p_last);
    assign iter_inc = {1'b0, r_iter} + (ITER_W+1)'(1);

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_c     = r_c;
        n_j     = r_j;
        n_iter  = r_iter;
        o_cmd       = '0;
        o_cmd.item  = i_item_index;
        o_cmd.coord = i_coord_index;
        o_cmd.value = i_coord_value;
        o_cmd.eps   = r_eps;
        o_cmd.iter  = r_iter;
        o_in_ready  = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.ld_pt  = (i_mode == MODE_LOAD_POINT);
                    o_cmd.ld_cen = (i_mode == MODE_LOAD_CENTROID);
                    if (i_mode == MODE_RUN) begin
                        o_cmd.run_start = 1'b1;
                        n_iter = '0;
                        n_p    = '0;
                        n_c    = '0;
                        n_j    = '0;
                        n_state = (r_max_it == '0) ? S_O_RD : S_CLR;
                    end
                end
            end
            S_CLR: begin
                o_cmd.iter_clr   = 1'b1;
                o_cmd.sum_clr_wr = 1'b1;
                if (j_end) begin
                    n_j = '0;
                    if (c_end) begin
                        n_c = '0;
                        n_p = '0;
                        n_state = S_A_RD;
                    end else begin
                        n_c = r_c + CW'(1);
                    end
                end else begin
                    n_j = r_j + DW'(1);
                end
            end
            S_A_RD: begin
                o_cmd.a_rd = 1'b1;
                n_state = S_A_SQ;
            end
            S_A_SQ: begin
                o_cmd.sq_ab = 1'b1;
                n_state = S_A_ACC;
            end
            S_A_ACC: begin
                o_cmd.dist_acc = 1'b1;
                o_cmd.first    = (r_j == '0);
                if (j_end) begin
                    n_j = '0;
                    n_state = S_A_CMP;
                end else begin
                    n_j = r_j + DW'(1);
                    n_state = S_A_RD;
                end
            end
            S_A_CMP: begin
                o_cmd.best_upd = 1'b1;
                o_cmd.first    = (r_c == '0);
                if (c_end) begin
                    n_c = '0;
                    n_state = S_U_RD;
                end else begin
                    n_c = r_c + CW'(1);
                    n_state = S_A_RD;
                end
            end
            S_U_RD: begin
                o_cmd.u_rd    = 1'b1;
                o_cmd.cnt_inc = (r_j == '0);
                n_state = S_U_WR;
            end
            S_U_WR: begin
                o_cmd.u_wr = 1'b1;
                if (j_end) begin
                    n_j = '0;
                    if (p_end) begin
                        n_p = '0;
                        n_c = '0;
                        n_state = S_M_CHK;
                    end else begin
                        n_p = r_p + PW'(1);
                        n_state = S_A_RD;
                    end
                end else begin
                    n_j = r_j + DW'(1);
                    n_state = S_U_RD;
                end
            end
            S_M_CHK: begin
                if (i_sts.count_zero) begin
                    n_state = S_ERR;
                end else begin
                    o_cmd.move_clr = 1'b1;
                    n_state = S_M_RD;
                end
            end
            S_M_RD: begin
                o_cmd.m_rd = 1'b1;
                n_state = S_M_DGO;
            end
            S_M_DGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_M_DWT;
            end
            S_M_DWT: begin
                if (i_sts.div_done) begin
                    n_state = S_M_MV;
                end
            end
            S_M_MV: begin
                o_cmd.sq_mc  = 1'b1;
                o_cmd.cen_wr = 1'b1;
                n_state = S_M_ACC;
            end
            S_M_ACC: begin
                o_cmd.move_acc = 1'b1;
                if (j_end) begin
                    n_j = '0;
                    n_state = S_M_MAX;
                end else begin
                    n_j = r_j + DW'(1);
                    n_state = S_M_RD;
                end
            end
            S_M_MAX: begin
                o_cmd.max_upd = 1'b1;
                if (c_end) begin
                    n_c = '0;
                    n_state = S_IT_END;
                end else begin
                    n_c = r_c + CW'(1);
                    n_state = S_M_CHK;
                end
            end
            S_IT_END: begin
                n_iter = iter_inc[ITER_W-1:0];
                n_c = '0;
                n_j = '0;
                if (i_sts.converged || (iter_inc >= {1'b0, r_max_it})) begin
                    n_state = S_O_RD;
                end else begin
                    n_state = S_CLR;
                end
            end
            S_O_RD: begin
                o_cmd.o_rd = 1'b1;
                n_state = S_O_SEND;
            end
            S_O_SEND: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = j_end && c_end;
                    if (j_end) begin
                        n_j = '0;
                        if (c_end) begin
                            n_c = '0;
                            n_state = S_IDLE;
                        end else begin
                            n_c = r_c + CW'(1);
                            n_state = S_O_RD;
                        end
                    end else begin
                        n_j = r_j + DW'(1);
                        n_state = S_O_RD;
                    end
                end
            end
            S_ERR: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_err  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_c = '0;
                    n_j = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_c     <= '0;
            r_j     <= '0;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_c     <= n_c;
            r_j     <= n_j;
            r_iter  <= n_iter;
        end
    end

    assign o_p = r_p;
    assign o_c = r_c;
    assign o_j = r_j;

endmodule

/* hdl/kmeans_lloyd_clustering.sv */
// ============================================================================
// kmeans_lloyd_clustering: Lloyd k-means engine on signed Q8.8 coordinates
// Top level joining the run sequencer and the datapath.
// ============================================================================
// Load words (point or initial centroid coordinates) are taken one per cycle.
// A run word blocks the input until the run has ended, then the final
// centroids come out as K*D words, cluster-major, or as a single error word
// when a cluster ends up empty. In each iteration the distance walk reads one
// coordinate pair at a time from stores with one read port each, and each
// centroid coordinate waits for a one-bit-per-cycle divider as wide as SUM_W,
// the sum width (26 bits at 1024 points). Reporting reads each word from the
// centroid store, then loads it into the output register once that is free.
// No clearing pass is needed after reset.
module kmeans_lloyd_clustering import kll_pkg::*; #(
    parameter int MAX_POINTS   = DEF_MAX_POINTS,
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
    parameter int MAX_DIMS     = DEF_MAX_DIMS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_mode,
    input  logic [ITEM_W-1:0]         i_item_index,
    input  logic [CIDX_W-1:0]         i_coord_index,
    input  logic signed [COORD_W-1:0] i_coord_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [CIDX_W-1:0]         o_cluster_index,
    output logic [CIDX_W-1:0]         o_out_coord_index,
    output logic signed [COORD_W-1:0] o_centroid_value,
    output logic                      o_status,
    output logic [ITER_W-1:0]         o_iterations_done,
    output logic                      o_last,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int PW = (MAX_POINTS   > 1) ? $clog2(MAX_POINTS)   : 1;
    localparam int CW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DW = (MAX_DIMS     > 1) ? $clog2(MAX_DIMS)     : 1;

    t_cmd          cmd;
    t_sts          sts;
    logic [PW-1:0] p_idx;
    logic [CW-1:0] c_idx;
    logic [DW-1:0] j_idx;

    kll_ctrl #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS),
        .PW (PW), .CW (CW), .DW (DW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_item_index  (i_item_index),
        .i_coord_index (i_coord_index),
        .i_coord_value (i_coord_value),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sts         (sts),
        .o_cmd         (cmd),
        .o_p           (p_idx),
        .o_c           (c_idx),
        .o_j           (j_idx)
    );

    kll_datapath #(
        .MAX_POINTS   (MAX_POINTS),
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS),
        .PW (PW), .CW (CW), .DW (DW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_p               (p_idx),
        .i_c               (c_idx),
        .i_j               (j_idx),
        .o_sts             (sts),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_cluster_index   (o_cluster_index),
        .o_out_coord_index (o_out_coord_index),
        .o_centroid_value  (o_centroid_value),
        .o_status          (o_status),
        .o_iterations_done (o_iterations_done),
        .o_last            (o_last)
    );

endmodule
